@@ src/utf8_stream_decoder_top_macros.svh @@
// Assertion macros used by the checker file of the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define UTF8SD_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("utf8sd: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define UTF8SD_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("utf8sd: next-cycle check failed");

`endif

@@ src/utf8sd_pkg.sv @@
// Constants shared by the UTF-8 stream decoder and its checker.
package utf8sd_pkg;

   localparam int MAX_TEXT_BYTES = 4096;

   localparam int BYTE_W   = 8;
   localparam int CP_W     = 21;
   localparam int OFFSET_W = 12;
   localparam int RSP_DATA_W = 40;

   // Highest offset the position counter reaches before it saturates.
   localparam int OFFSET_LIMIT_INT = (MAX_TEXT_BYTES - 1 > 4095) ? 4095 : MAX_TEXT_BYTES - 1;
   localparam logic [OFFSET_W-1:0] OFFSET_LIMIT = OFFSET_W'(OFFSET_LIMIT_INT);

   localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
   localparam logic [CP_W-1:0] SURROGATE_LO = 21'h00D800;
   localparam logic [CP_W-1:0] SURROGATE_HI = 21'h00DFFF;

   // Result status codes, carried on the result tuser.
   localparam logic STATUS_VALID = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

endpackage

@@ src/utf8_stream_decoder_top.sv @@
// Top level of the lax UTF-8 stream decoder.

// The decoder takes one byte of text per request and returns decoded code points,
// each with the byte offset of its lead byte. A byte below 0x80 is a code point by
// itself; a lead byte of 0xF0 or more expects three continuation bytes, 0xE0 or more
// expects two and any other byte expects one. Overlong forms are accepted. A bad
// continuation byte, a text that ends inside a sequence, a value above 0x10FFFF or a
// surrogate gives one error response (status 1, code point 0) at the sequence's start
// offset, after which the rest of that text produces nothing. The request carrying
// tlast ends the text and the next byte starts again at offset 0. Offsets saturate
// at the smaller of MAX_TEXT_BYTES-1 and 4095. A request is taken in every cycle as
// long as the response side keeps up: each byte is held in the input register and
// is decoded in one pass from there into the response register, which drives the
// response port. The only stall comes from the response register, when it holds
// a response that the consumer has not taken.
module utf8_stream_decoder_top
   import utf8sd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] text_byte
   input  logic                  req_tlast,   // text_last
   // Response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [20:0] code_point, [32:21] start_offset,
                                              // [39:33] zero
   output logic                  rsp_tuser,   // status
   output logic                  rsp_tlast    // text_end
);

   // Input register: holds one accepted request until it is decoded.
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   // Decoder state.
   logic [1:0]          pending_ff, pending_in;
   logic [CP_W-1:0]     acc_ff, acc_in;
   logic [OFFSET_W-1:0] pos_ff, pos_in;
   logic [OFFSET_W-1:0] start_ff, start_in;
   logic                skip_ff, skip_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0]     rsp_cp_ff, rsp_cp_in;
   logic [OFFSET_W-1:0] rsp_off_ff, rsp_off_in;
   logic                rsp_status_ff, rsp_status_in;
   logic                rsp_end_ff, rsp_end_in;

   logic            advance;   // the held request is decoded this cycle
   logic            emit;
   logic [CP_W-1:0] acc_next;
   logic            range_bad;

   // The held byte moves on once the response register is free or being emptied.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = req_tvalid ? 1'b1 : (in_valid_ff && !advance);
   end

   // Continuation byte contributes its low six bits.
   assign acc_next  = {acc_ff[CP_W-7:0], in_byte_ff[5:0]};
   assign range_bad = (acc_next > CP_MAX) ||
                      ((acc_next >= SURROGATE_LO) && (acc_next <= SURROGATE_HI));

   // One decoding step for the held byte.
   always_comb begin
      pending_in    = pending_ff;
      acc_in        = acc_ff;
      start_in      = start_ff;
      skip_in       = skip_ff;
      pos_in        = (pos_ff < OFFSET_LIMIT) ? pos_ff + 1'b1 : pos_ff;
      emit          = 1'b0;
      rsp_cp_in     = '0;
      rsp_off_in    = start_ff;
      rsp_status_in = STATUS_ERROR;
      rsp_end_in    = in_last_ff;

      if (skip_ff) begin
         // Rest of the text is ignored after an error.
      end else if (pending_ff == 2'd0) begin
         if (!in_byte_ff[7]) begin
            emit          = 1'b1;
            rsp_cp_in     = {{(CP_W-BYTE_W){1'b0}}, in_byte_ff};
            rsp_off_in    = pos_ff;
            rsp_status_in = STATUS_VALID;
         end else begin
            start_in = pos_ff;
            if (in_last_ff) begin
               emit       = 1'b1;
               rsp_off_in = pos_ff;
            end else if (in_byte_ff >= 8'hF0) begin
               pending_in = 2'd3;
               acc_in     = {{(CP_W-3){1'b0}}, in_byte_ff[2:0]};
            end else if (in_byte_ff >= 8'hE0) begin
               pending_in = 2'd2;
               acc_in     = {{(CP_W-4){1'b0}}, in_byte_ff[3:0]};
            end else begin
               pending_in = 2'd1;
               acc_in     = {{(CP_W-5){1'b0}}, in_byte_ff[4:0]};
            end
         end
      end else if (in_byte_ff[7:6] != 2'b10) begin
         // Not a continuation byte: one error, then skip to the end of the text.
         emit       = 1'b1;
         pending_in = 2'd0;
         acc_in     = '0;
         skip_in    = 1'b1;
      end else begin
         pending_in = pending_ff - 1'b1;
         acc_in     = acc_next;
         if (pending_ff == 2'd1) begin
            emit   = 1'b1;
            acc_in = '0;
            if (range_bad) begin
               skip_in = 1'b1;
            end else begin
               rsp_cp_in     = acc_next;
               rsp_status_in = STATUS_VALID;
            end
         end else if (in_last_ff) begin
            emit = 1'b1;
         end
      end

      // The final byte of a text clears everything for the next one.
      if (in_last_ff) begin
         pending_in = 2'd0;
         acc_in     = '0;
         pos_in     = '0;
         start_in   = '0;
         skip_in    = 1'b0;
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= 2'd0;
         acc_ff       <= '0;
         pos_ff       <= '0;
         start_ff     <= '0;
         skip_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            pending_ff <= pending_in;
            acc_ff     <= acc_in;
            pos_ff     <= pos_in;
            start_ff   <= start_in;
            skip_ff    <= skip_in;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && emit) begin
         rsp_cp_ff     <= rsp_cp_in;
         rsp_off_ff    <= rsp_off_in;
         rsp_status_ff <= rsp_status_in;
         rsp_end_ff    <= rsp_end_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-CP_W-OFFSET_W){1'b0}}, rsp_off_ff, rsp_cp_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_end_ff;

endmodule

@@ src/utf8sd_checker.sv @@
// Port-level checker for the UTF-8 stream decoder, bound to its top level.
`include "utf8_stream_decoder_top_macros.svh"

module utf8sd_checker
   import utf8sd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [BYTE_W-1:0]     req_tdata,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast
);

   logic [CP_W-1:0]         cp;
   logic                    rsp_stall;
   logic                    req_stall;
   logic                    err_rsp;
   logic                    ok_rsp;
   logic                    cp_scalar;
   logic [RSP_DATA_W+1:0]   rsp_word;
   logic [BYTE_W:0]         req_word;

   assign cp        = rsp_tdata[CP_W-1:0];
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_stall = req_tvalid && !req_tready;
   assign err_rsp   = rsp_tvalid && (rsp_tuser == STATUS_ERROR);
   assign ok_rsp    = rsp_tvalid && (rsp_tuser == STATUS_VALID);
   assign cp_scalar = (cp <= CP_MAX) && ((cp < SURROGATE_LO) || (cp > SURROGATE_HI));
   assign rsp_word  = {rsp_tdata, rsp_tuser, rsp_tlast};
   assign req_word  = {req_tdata, req_tlast};

   // A response that is not taken stays offered and unchanged.
   `UTF8SD_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // A request that is refused stays offered and unchanged.
   `UTF8SD_ASSERT_NEXT(a_req_held, clock, reset, req_stall, req_tvalid && $stable(req_word))

   // Error responses carry a zero code point.
   `UTF8SD_ASSERT_NOW(a_err_zero, clock, reset, err_rsp, cp == '0)

   // Valid responses are Unicode scalar values.
   `UTF8SD_ASSERT_NOW(a_scalar, clock, reset, ok_rsp, cp_scalar)

   // Padding above the start offset is always zero.
   `UTF8SD_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[RSP_DATA_W-1:CP_W+OFFSET_W] == '0)

endmodule

bind utf8_stream_decoder_top utf8sd_checker u_checker (.*);
